@@ hw/rtl/lawd_pkg.sv @@
// Shared types and constants for the load-aware worker dispatcher.
// Used by lawd_ctrl, lawd_dp and load_aware_worker_dispatcher_core.
`timescale 1ns / 1ps

package lawd_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int LOAD_W  = 8;
  localparam int PROC_W  = 32;
  localparam int WC_W    = 5;

  localparam logic [LOAD_W-1:0] LOAD_LIMIT_RESET = LOAD_W'(5);
  localparam logic [WC_W-1:0]   WC_RESET         = WC_W'(16);

  localparam logic [1:0] REG_MODE       = 2'd0;
  localparam logic [1:0] REG_LOAD_LIMIT = 2'd1;
  localparam logic [1:0] REG_WC         = 2'd2;

  localparam logic KIND_WRITE   = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  localparam logic MODE_RR = 1'b0;
  localparam logic MODE_LL = 1'b1;

  typedef struct packed {
    logic capture;
    logic scan_step;
    logic commit;
    logic out_load;
  } lawd_cmd_t;

  typedef struct packed {
    logic is_write;
    logic none;
    logic hit;
    logic last;
  } lawd_sts_t;

endpackage

@@ hw/rtl/load_aware_worker_dispatcher_core.sv @@
// Load-aware worker dispatcher top level: joins lawd_ctrl and lawd_dp, uses lawd_pkg.
// One transaction is in work at a time. A request scans k entries (0 to 16, one entry
// a cycle; round robin stops at the first eligible entry). An item holds the block until
// its result is loaded into the output register, which can wait on m_axis_tready.
// Synchronous reset clears the table and pointer, mode 0, limit 5.
`timescale 1ns / 1ps

module load_aware_worker_dispatcher_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // entry_index[3:0], entry_active[4], entry_load[12:5], entry_processed[44:13]
  input  logic [47:0] s_axis_tdata,
  // kind[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // chosen_index[3:0], chosen_load[11:4]
  output logic [15:0] m_axis_tdata,
  // found[0]
  output logic        m_axis_tuser
);

  lawd_pkg::lawd_cmd_t cmd;
  lawd_pkg::lawd_sts_t sts;

  logic [lawd_pkg::IDX_W-1:0]  out_index;
  logic [lawd_pkg::LOAD_W-1:0] out_load;

  lawd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lawd_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .in_kind      (s_axis_tuser),
    .in_index     (s_axis_tdata[3:0]),
    .in_active    (s_axis_tdata[4]),
    .in_load      (s_axis_tdata[12:5]),
    .in_processed (s_axis_tdata[44:13]),
    .cmd          (cmd),
    .sts          (sts),
    .out_found    (m_axis_tuser),
    .out_index    (out_index),
    .out_load     (out_load)
  );

  assign m_axis_tdata = {4'b0000, out_load, out_index};

endmodule

@@ hw/rtl/lawd_ctrl.sv @@
// Controller state machine of the worker dispatcher.
// Depends on lawd_pkg for the command and status structs.
`timescale 1ns / 1ps

module lawd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  lawd_pkg::lawd_sts_t sts,
  output lawd_pkg::lawd_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_FINISH
  } state_t;

  state_t state;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE);

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE:   cmd.capture   = in_valid;
      ST_SCAN:   cmd.scan_step = !sts.none;
      ST_COMMIT: cmd.commit    = 1'b1;
      ST_FINISH: cmd.out_load  = slot_free;
      default:   cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (sts.is_write) begin
            state <= ST_FINISH;
          end else if (sts.none || sts.hit || sts.last) begin
            state <= ST_COMMIT;
          end
        end
        ST_COMMIT: state <= ST_FINISH;
        ST_FINISH: begin
          if (slot_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/lawd_dp.sv @@
// Datapath of the worker dispatcher: worker table, configuration registers,
// scan unit and result registers. Depends on lawd_pkg.
`timescale 1ns / 1ps

module lawd_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [1:0]                    cfg_addr,
  input  logic [lawd_pkg::LOAD_W-1:0]   cfg_wdata,
  input  logic                          in_kind,
  input  logic [lawd_pkg::IDX_W-1:0]    in_index,
  input  logic                          in_active,
  input  logic [lawd_pkg::LOAD_W-1:0]   in_load,
  input  logic [lawd_pkg::PROC_W-1:0]   in_processed,
  input  lawd_pkg::lawd_cmd_t           cmd,
  output lawd_pkg::lawd_sts_t           sts,
  output logic                          out_found,
  output logic [lawd_pkg::IDX_W-1:0]    out_index,
  output logic [lawd_pkg::LOAD_W-1:0]   out_load
);

  logic                          active_flags    [lawd_pkg::ENTRIES];
  logic [lawd_pkg::LOAD_W-1:0]   load_table      [lawd_pkg::ENTRIES];
  logic [lawd_pkg::PROC_W-1:0]   processed_table [lawd_pkg::ENTRIES];

  logic                          mode;
  logic [lawd_pkg::LOAD_W-1:0]   load_limit;
  logic [lawd_pkg::WC_W-1:0]     worker_count;
  logic [lawd_pkg::IDX_W-1:0]    rotate_pointer;

  logic                          is_write;
  logic [lawd_pkg::IDX_W-1:0]    scan_idx;
  logic [lawd_pkg::CNT_W-1:0]    scan_cnt;
  logic                          have;
  logic [lawd_pkg::IDX_W-1:0]    best_idx;
  logic [lawd_pkg::LOAD_W-1:0]   best_load;
  logic [lawd_pkg::PROC_W-1:0]   best_proc;

  logic                          res_found;
  logic [lawd_pkg::IDX_W-1:0]    res_index;
  logic [lawd_pkg::LOAD_W-1:0]   res_load;

  logic [lawd_pkg::CNT_W-1:0]    used;
  logic [lawd_pkg::CNT_W-1:0]    used_m1;
  logic                          cur_active;
  logic [lawd_pkg::LOAD_W-1:0]   cur_load;
  logic [lawd_pkg::PROC_W-1:0]   cur_proc;
  logic                          cur_elig;
  logic                          cur_better;
  logic [lawd_pkg::IDX_W-1:0]    idx_next;
  logic [lawd_pkg::IDX_W-1:0]    ptr_next;

  assign used = (worker_count > lawd_pkg::WC_W'(lawd_pkg::ENTRIES))
                ? lawd_pkg::CNT_W'(lawd_pkg::ENTRIES)
                : lawd_pkg::CNT_W'(worker_count);
  assign used_m1 = used - lawd_pkg::CNT_W'(1);

  assign cur_active = active_flags[scan_idx];
  assign cur_load   = load_table[scan_idx];
  assign cur_proc   = processed_table[scan_idx];
  assign cur_elig   = cur_active && (cur_load < load_limit);

  always_comb begin
    if (mode == lawd_pkg::MODE_RR) begin
      cur_better = cur_elig && !have;
    end else begin
      cur_better = cur_elig && (!have || (cur_load < best_load) ||
                   ((cur_load == best_load) && (cur_proc < best_proc)));
    end
  end

  assign idx_next = (lawd_pkg::CNT_W'(scan_idx) == used_m1)
                    ? '0 : scan_idx + lawd_pkg::IDX_W'(1);
  assign ptr_next = (lawd_pkg::CNT_W'(best_idx) == used_m1)
                    ? '0 : best_idx + lawd_pkg::IDX_W'(1);

  assign sts.is_write = is_write;
  assign sts.none     = (used == '0);
  assign sts.hit      = (mode == lawd_pkg::MODE_RR) && cur_elig;
  assign sts.last     = (scan_cnt == used_m1);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= lawd_pkg::MODE_RR;
      load_limit     <= lawd_pkg::LOAD_LIMIT_RESET;
      worker_count   <= lawd_pkg::WC_RESET;
      rotate_pointer <= '0;
      for (int i = 0; i < lawd_pkg::ENTRIES; i++) begin
        active_flags[i]    <= 1'b0;
        load_table[i]      <= '0;
        processed_table[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          lawd_pkg::REG_MODE:       mode <= cfg_wdata[0];
          lawd_pkg::REG_LOAD_LIMIT: load_limit <= cfg_wdata;
          lawd_pkg::REG_WC: begin
            worker_count   <= cfg_wdata[lawd_pkg::WC_W-1:0];
            rotate_pointer <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.capture && (in_kind == lawd_pkg::KIND_WRITE)) begin
        active_flags[in_index]    <= in_active;
        load_table[in_index]      <= in_load;
        processed_table[in_index] <= in_processed;
      end
      if (cmd.commit && have) begin
        if (mode == lawd_pkg::MODE_RR) begin
          rotate_pointer <= ptr_next;
        end else if (best_proc != '1) begin
          processed_table[best_idx] <= best_proc + lawd_pkg::PROC_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
    end else if (cmd.capture) begin
      have <= 1'b0;
    end else if (cmd.scan_step && cur_better) begin
      have <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      is_write <= (in_kind == lawd_pkg::KIND_WRITE);
      scan_idx <= (mode == lawd_pkg::MODE_RR) ? rotate_pointer : '0;
      scan_cnt <= '0;
    end else if (cmd.scan_step) begin
      scan_idx <= idx_next;
      scan_cnt <= scan_cnt + lawd_pkg::CNT_W'(1);
    end
    if (cmd.scan_step && cur_better) begin
      best_idx  <= scan_idx;
      best_load <= cur_load;
      best_proc <= cur_proc;
    end
    if (cmd.capture) begin
      res_found <= 1'b0;
      res_index <= '0;
      res_load  <= '0;
    end else if (cmd.commit && have) begin
      res_found <= 1'b1;
      res_index <= best_idx;
      res_load  <= best_load;
    end
    if (cmd.out_load) begin
      out_found <= res_found;
      out_index <= res_index;
      out_load  <= res_load;
    end
  end

endmodule

@@ tb/sv/load_aware_worker_dispatcher_core_tb.sv @@
// Self-checking testbench for load_aware_worker_dispatcher_core: a directed table,
// then randomized configuration phases, each result checked against a local predictor or a typed expectation.
// Depends on lawd_pkg and load_aware_worker_dispatcher_core.
`timescale 1ns / 1ps

module load_aware_worker_dispatcher_core_tb;

  localparam int NUM_PHASES      = 12;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int SETTLE_CYCLES   = 24;
  localparam int CYCLE_LIMIT     = 1000000;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam bit TYPED     = 1'b1;
  localparam bit PREDICTED = 1'b0;

  typedef struct packed {
    logic        kind;
    logic [3:0]  entry_index;
    logic        entry_active;
    logic [7:0]  entry_load;
    logic [31:0] entry_processed;
  } dispatch_item_t;

  typedef struct packed {
    logic       found;
    logic [3:0] chosen_index;
    logic [7:0] chosen_load;
  } pick_t;

  typedef struct packed {
    logic           is_cfg;
    logic [1:0]     addr;
    logic [7:0]     value;
    dispatch_item_t item;
    logic           typed;
    pick_t          want;
  } plan_row_t;

  localparam pick_t NO_PICK = '0;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [1:0]  cfg_addr;
  logic [7:0]  cfg_wdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // entry_index[3:0], entry_active[4], entry_load[12:5], entry_processed[44:13]
  logic [47:0] s_axis_tdata;
  // kind[0]
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // chosen_index[3:0], chosen_load[11:4]
  logic [15:0] m_axis_tdata;
  // found[0]
  logic        m_axis_tuser;

  load_aware_worker_dispatcher_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Predictor copy of the worker table and registers.
  logic        worker_active [lawd_pkg::ENTRIES];
  logic [7:0]  worker_load   [lawd_pkg::ENTRIES];
  logic [31:0] worker_done   [lawd_pkg::ENTRIES];
  logic [3:0]  rr_ptr;
  logic        cur_mode;
  logic [7:0]  cur_load_limit;
  logic [4:0]  cur_worker_count;

  pick_t     pending_picks[$];
  plan_row_t plan[$];

  bit stall_ok;
  int cycles;
  int mismatches;
  int results;
  int found_count;
  int writes_sent;
  int requests_sent;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic void apply_reg(input logic [1:0] addr, input logic [7:0] value);
    case (addr)
      lawd_pkg::REG_MODE: begin
        cur_mode = value[0];
      end
      lawd_pkg::REG_LOAD_LIMIT: begin
        cur_load_limit = value;
      end
      lawd_pkg::REG_WC: begin
        cur_worker_count = value[4:0];
        rr_ptr = '0;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic bit can_take(input int i);
    return worker_active[i] && (worker_load[i] < cur_load_limit);
  endfunction

  function automatic int used_entries();
    return (cur_worker_count > lawd_pkg::ENTRIES) ? lawd_pkg::ENTRIES
                                                  : int'(cur_worker_count);
  endfunction

  // Applies one item to the predictor state and returns the result it causes.
  function automatic pick_t dispatch(input dispatch_item_t it);
    pick_t res;
    int n;
    int start;
    int idx;
    int best;
    bit have;
    res = NO_PICK;
    have = 1'b0;
    best = 0;
    if (it.kind == lawd_pkg::KIND_WRITE) begin
      worker_active[it.entry_index] = it.entry_active;
      worker_load[it.entry_index]   = it.entry_load;
      worker_done[it.entry_index]   = it.entry_processed;
      return res;
    end
    n = used_entries();
    if (n == 0) return res;
    if (cur_mode == lawd_pkg::MODE_RR) begin
      start = int'(rr_ptr) % n;
      for (int k = 0; k < n && !have; k++) begin
        idx = (start + k) % n;
        if (can_take(idx)) begin
          have = 1'b1;
          best = idx;
          rr_ptr = 4'((idx + 1) % n);
        end
      end
    end else begin
      for (int i = 0; i < n; i++) begin
        if (can_take(i) && (!have || worker_load[i] < worker_load[best] ||
            (worker_load[i] == worker_load[best] && worker_done[i] < worker_done[best]))) begin
          best = i;
          have = 1'b1;
        end
      end
      if (have && worker_done[best] != 32'hFFFF_FFFF) worker_done[best]++;
    end
    if (have) begin
      res.found = 1'b1;
      res.chosen_index = 4'(best);
      res.chosen_load = worker_load[best];
    end
    return res;
  endfunction

  function automatic pick_t pick(input logic f, input logic [3:0] i, input logic [7:0] l);
    pick_t p;
    p.found = f;
    p.chosen_index = i;
    p.chosen_load = l;
    return p;
  endfunction

  function automatic plan_row_t cfg_row(input logic [1:0] addr, input logic [7:0] value);
    plan_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.addr = addr;
    r.value = value;
    return r;
  endfunction

  function automatic plan_row_t wr_row(input logic [3:0] i, input logic act, input logic [7:0] ld,
                                       input logic [31:0] pr, input bit typed, input pick_t want);
    plan_row_t r;
    r = '0;
    r.item.kind = lawd_pkg::KIND_WRITE;
    r.item.entry_index = i;
    r.item.entry_active = act;
    r.item.entry_load = ld;
    r.item.entry_processed = pr;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic plan_row_t req_row(input bit typed, input pick_t want);
    plan_row_t r;
    r = '0;
    r.item.kind = lawd_pkg::KIND_REQUEST;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic int draw_gap();
    if (stall_ok && $urandom_range(0, 3) == 0) return $urandom_range(1, 16);
    return 0;
  endfunction

  task automatic send_item(input dispatch_item_t it, input int gap, input bit typed,
                           input pick_t want);
    pick_t got;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, it.entry_processed, it.entry_load, it.entry_active,
                      it.entry_index};
    s_axis_tuser  <= it.kind;
    do @(posedge clk); while (!s_axis_tready);
    got = dispatch(it);
    pending_picks.push_back(typed ? want : got);
    if (it.kind == lawd_pkg::KIND_WRITE) writes_sent++;
    else requests_sent++;
  endtask

  // Lowers valid right after an accepted transaction and waits until the block is idle.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_picks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] addr, input logic [7:0] value);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    apply_reg(addr, value);
  endtask

  always @(posedge clk) begin : check_results
    pick_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_picks.size() == 0) begin
        $error("result transaction with no request pending");
        mismatches++;
      end else begin
        want = pending_picks.pop_front();
        results++;
        if (m_axis_tuser) found_count++;
        if (m_axis_tuser !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, m_axis_tuser);
          mismatches++;
        end
        if (m_axis_tdata[3:0] !== want.chosen_index) begin
          $error("chosen_index: expected %0d, actual %0d", want.chosen_index,
                 m_axis_tdata[3:0]);
          mismatches++;
        end
        if (m_axis_tdata[11:4] !== want.chosen_load) begin
          $error("chosen_load: expected %0d, actual %0d", want.chosen_load,
                 m_axis_tdata[11:4]);
          mismatches++;
        end
      end
    end
  end

  initial begin : result_sink
    m_axis_tready <= 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (stall_ok && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  initial begin : stimulus
    dispatch_item_t it;
    logic [7:0] value;
    int n_used;
    rst           <= 1'b1;
    cfg_wr_en     <= 1'b0;
    cfg_addr      <= lawd_pkg::REG_MODE;
    cfg_wdata     <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= lawd_pkg::KIND_WRITE;
    stall_ok = 1'b1;
    for (int i = 0; i < lawd_pkg::ENTRIES; i++) begin
      worker_active[i] = 1'b0;
      worker_load[i] = '0;
      worker_done[i] = '0;
    end
    rr_ptr = '0;
    cur_mode = lawd_pkg::MODE_RR;
    cur_load_limit = lawd_pkg::LOAD_LIMIT_RESET;
    cur_worker_count = lawd_pkg::WC_RESET;

    plan.push_back(req_row(TYPED, NO_PICK));
    plan.push_back(wr_row(4'd0, 1'b1, 8'd0, 32'd0, TYPED, NO_PICK));
    plan.push_back(wr_row(4'd15, 1'b1, 8'd255, 32'hFFFF_FFFF, TYPED, NO_PICK));
    plan.push_back(wr_row(4'd7, 1'b1, 8'd4, 32'd0, PREDICTED, NO_PICK));
    plan.push_back(req_row(TYPED, pick(1'b1, 4'd0, 8'd0)));
    plan.push_back(req_row(TYPED, pick(1'b1, 4'd7, 8'd4)));
    plan.push_back(req_row(PREDICTED, NO_PICK));
    plan.push_back(cfg_row(lawd_pkg::REG_LOAD_LIMIT, 8'd255));
    plan.push_back(req_row(PREDICTED, NO_PICK));
    plan.push_back(req_row(PREDICTED, NO_PICK));
    plan.push_back(cfg_row(lawd_pkg::REG_LOAD_LIMIT, 8'd0));
    plan.push_back(req_row(TYPED, NO_PICK));
    plan.push_back(cfg_row(lawd_pkg::REG_MODE, 8'hFF));
    plan.push_back(cfg_row(lawd_pkg::REG_LOAD_LIMIT, 8'd5));
    plan.push_back(wr_row(4'd3, 1'b1, 8'd0, 32'hFFFF_FFFF, PREDICTED, NO_PICK));
    plan.push_back(req_row(PREDICTED, NO_PICK));
    plan.push_back(wr_row(4'd0, 1'b1, 8'd0, 32'hFFFF_FFFE, PREDICTED, NO_PICK));
    plan.push_back(req_row(PREDICTED, NO_PICK));
    plan.push_back(req_row(PREDICTED, NO_PICK));
    plan.push_back(wr_row(4'd0, 1'b0, 8'd0, 32'd0, PREDICTED, NO_PICK));
    plan.push_back(req_row(PREDICTED, NO_PICK));
    plan.push_back(cfg_row(lawd_pkg::REG_WC, 8'd0));
    plan.push_back(req_row(TYPED, NO_PICK));
    plan.push_back(cfg_row(lawd_pkg::REG_WC, 8'hFF));
    plan.push_back(cfg_row(REG_SPARE, 8'h00));
    plan.push_back(req_row(PREDICTED, NO_PICK));
    plan.push_back(cfg_row(lawd_pkg::REG_MODE, 8'd2));
    plan.push_back(cfg_row(lawd_pkg::REG_WC, 8'd4));
    plan.push_back(wr_row(4'd2, 1'b1, 8'd1, 32'd0, PREDICTED, NO_PICK));
    plan.push_back(req_row(PREDICTED, NO_PICK));
    plan.push_back(req_row(PREDICTED, NO_PICK));
    plan.push_back(req_row(PREDICTED, NO_PICK));
    plan.push_back(cfg_row(lawd_pkg::REG_WC, 8'd1));
    plan.push_back(req_row(TYPED, NO_PICK));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[r]) begin
      if (plan[r].is_cfg) begin
        settle();
        write_reg(plan[r].addr, plan[r].value);
      end else begin
        send_item(plan[r].item, draw_gap(), plan[r].typed, plan[r].want);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      stall_ok = !(ph == 3 || ph >= NUM_PHASES - 2);
      if ($urandom_range(0, 3) != 0) begin
        write_reg(lawd_pkg::REG_MODE, 8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 9))
          0: value = 8'd0;
          1: value = 8'd1;
          2: value = 8'd255;
          3, 4: value = 8'($urandom_range(0, 255));
          default: value = 8'($urandom_range(2, 8));
        endcase
        write_reg(lawd_pkg::REG_LOAD_LIMIT, value);
      end
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 9))
          0: value = 8'd16;
          1: value = 8'd1;
          2: value = 8'($urandom_range(0, 31));
          3: value = 8'($urandom_range(17, 255));
          default: value = 8'($urandom_range(2, 15));
        endcase
        write_reg(lawd_pkg::REG_WC, value);
      end
      if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, 8'($urandom_range(0, 255)));

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (ph == 5 && k == ITEMS_PER_PHASE / 2) settle();
        n_used = used_entries();
        it.kind = ($urandom_range(0, 99) < 55) ? lawd_pkg::KIND_REQUEST : lawd_pkg::KIND_WRITE;
        it.entry_index = (n_used > 0 && $urandom_range(0, 4) != 0) ?
                         4'($urandom_range(0, n_used - 1)) : 4'($urandom_range(0, 15));
        it.entry_active = ($urandom_range(0, 4) != 0);
        it.entry_load = ($urandom_range(0, 9) < 7) ?
                        8'($urandom_range(0, cur_load_limit)) : 8'($urandom);
        case ($urandom_range(0, 4))
          0, 1: it.entry_processed = $urandom_range(0, 3);
          2: it.entry_processed = 32'hFFFF_FFFF - $urandom_range(0, 2);
          default: it.entry_processed = $urandom;
        endcase
        send_item(it, draw_gap(), PREDICTED, NO_PICK);
      end
    end

    settle();
    $display("Sent %0d write and %0d request transactions over %0d random phases.",
             writes_sent, requests_sent, NUM_PHASES);
    $display("Checked %0d results, %0d with a worker chosen; %0d mismatches in %0d cycles.",
             results, found_count, mismatches, cycles);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
